FILE: rtl/att_pkg.sv
package att_pkg;

   // Fixed formats of the sample and angle fields
   localparam int ACCEL_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_W         = 18;
   localparam int ZACC_FRAC       = 24;
   localparam int PRESCALE        = 31 - ACCEL_WIDTH;
   localparam int ROUND_SHIFT     = ZACC_FRAC - ANGLE_FRAC_BITS;

   // Datapath widths: CORDIC x/y, angle accumulator, square root
   localparam int DATA_W     = 35;
   localparam int ZACC_W     = 34;
   localparam int SQ_W       = 31;
   localparam int ROOT_W     = 63;
   localparam int SQRT_STEPS = 32;
   localparam int ATAN_LEN   = 24;

   // Angle limits in output LSBs
   localparam int ROLL_LIM  = 180 << ANGLE_FRAC_BITS;
   localparam int PITCH_LIM = 90 << ANGLE_FRAC_BITS;
   localparam int SUM_LIM   = 360 << ANGLE_FRAC_BITS;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_SWAP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE    = 2'd2;

   // atan(2^-i) in 2^-24 degree
   localparam logic [30:0] ATAN_TAB [ATAN_LEN] = '{
      31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
      31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
      31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
      31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229, 31'd115};

   // One pipeline stage: roll vector, pitch vector, square root state
   typedef struct packed {
      logic                     roll_zero;
      logic                     pitch_zero;
      logic signed [DATA_W-1:0] rx;
      logic signed [DATA_W-1:0] ry;
      logic signed [ZACC_W-1:0] rz;
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic signed [ZACC_W-1:0] pz;
      logic [SQ_W-1:0]          sqa;
      logic [SQ_W-1:0]          sqb;
      logic [ROOT_W-1:0]        rem;
      logic [ROOT_W-1:0]        root;
   } stage_type;

endpackage

FILE: rtl/att_req_if.sv
interface att_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [att_pkg::ACCEL_WIDTH-1:0] accel_x;
   logic signed [att_pkg::ACCEL_WIDTH-1:0] accel_y;
   logic signed [att_pkg::ACCEL_WIDTH-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink (input valid, input accel_x, input accel_y, input accel_z,
                 output ready);
endinterface

FILE: rtl/att_rsp_if.sv
interface att_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [att_pkg::ANGLE_W-1:0] roll_angle;
   logic signed [att_pkg::ANGLE_W-1:0] pitch_angle;

   modport source (output valid, output roll_angle, output pitch_angle, input ready);
   modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

FILE: rtl/accel_tilt_angles.sv
// Accelerometer tilt angles.
// req_chan carries one signed x/y/z sample per request (valid/ready); rsp_chan
// returns roll_angle and pitch_angle in 1/256 degree, one response per request,
// in request order.
// The pipeline from request to response valid is one intake stage with the
// squaring multipliers, one sum stage, 32 square-root stages (one result bit
// each), one stage per CORDIC iteration with roll and pitch side by side, and
// an output register for rounding, clamping, offset and swap.
// Throughput is one request per cycle while rsp_chan is not stalled; the whole
// pipeline moves as one.
// When the receiver holds rsp_chan.ready low with a response waiting, the
// pipeline freezes and req_chan.ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets zero_offset 0, axis_swap 0,
// deadzone 1. csr_we writes csr_wdata into register csr_index (0 zero_offset,
// 1 axis_swap, 2 deadzone); write only while no request is in flight.
module accel_tilt_angles #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic clock,
   input  logic reset,
   att_req_if.sink   req_chan,
   att_rsp_if.source rsp_chan,
   input  logic                                csr_we,
   input  logic [att_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [att_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DW  = att_pkg::DATA_W;
   localparam int ZW  = att_pkg::ZACC_W;
   localparam int RW  = att_pkg::ROOT_W;
   localparam int SQS = att_pkg::SQRT_STEPS;
   localparam int NST = 2 + SQS + CORDIC_ITERATIONS;
   localparam int SH  = att_pkg::ROUND_SHIFT;
   localparam int AW  = att_pkg::ANGLE_W;

   // Configuration registers
   logic signed [16:0] zero_offset_ff;
   logic               axis_swap_ff;
   logic [14:0]        deadzone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= '0;
         axis_swap_ff   <= 1'b0;
         deadzone_ff    <= 15'd1;
      end else if (csr_we) begin
         case (csr_index)
            att_pkg::CSR_ZERO_OFFSET: zero_offset_ff <= csr_wdata;
            att_pkg::CSR_AXIS_SWAP:   axis_swap_ff   <= csr_wdata[0];
            att_pkg::CSR_DEADZONE:    deadzone_ff    <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Pipeline storage and flow control
   att_pkg::stage_type pipe_ff [NST];
   att_pkg::stage_type pipe_in [NST];
   logic [NST-1:0]     vld_ff;
   logic               out_vld_ff;
   logic signed [AW-1:0] roll_out_ff, roll_out_in;
   logic signed [AW-1:0] pitch_out_ff, pitch_out_in;
   logic               advance;

   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Intake: deadzone test, quadrant pre-rotation, squares of y and z
   logic signed [16:0] ax_w, ay_w, az_w, xs_w, ys_w;
   logic [16:0]        aay_w, aaz_w;
   logic signed [31:0] sqy_w, sqz_w;

   assign ax_w  = {req_chan.accel_x[15], req_chan.accel_x};
   assign ay_w  = {req_chan.accel_y[15], req_chan.accel_y};
   assign az_w  = {req_chan.accel_z[15], req_chan.accel_z};
   assign aay_w = ay_w[16] ? 17'(-ay_w) : 17'(ay_w);
   assign aaz_w = az_w[16] ? 17'(-az_w) : 17'(az_w);
   assign sqy_w = req_chan.accel_y * req_chan.accel_y;
   assign sqz_w = req_chan.accel_z * req_chan.accel_z;

   always_comb begin
      pipe_in[0] = '0;
      pipe_in[0].roll_zero = (aay_w < {2'b00, deadzone_ff} && aaz_w < {2'b00, deadzone_ff})
                             || (ay_w == 17'sd0 && az_w == 17'sd0);
      pipe_in[0].pitch_zero = ax_w == 17'sd0 && ay_w == 17'sd0 && az_w == 17'sd0;
      xs_w = az_w;
      ys_w = ay_w;
      if (az_w[16]) begin
         if (!ay_w[16]) begin
            xs_w = ay_w;
            ys_w = 17'(-az_w);
            pipe_in[0].rz = ZW'(90) <<< att_pkg::ZACC_FRAC;
         end else begin
            xs_w = 17'(-ay_w);
            ys_w = az_w;
            pipe_in[0].rz = -(ZW'(90) <<< att_pkg::ZACC_FRAC);
         end
      end
      pipe_in[0].rx  = DW'(xs_w) <<< att_pkg::PRESCALE;
      pipe_in[0].ry  = DW'(ys_w) <<< att_pkg::PRESCALE;
      pipe_in[0].py  = DW'(17'(-ax_w)) <<< att_pkg::PRESCALE;
      pipe_in[0].sqa = sqy_w[att_pkg::SQ_W-1:0];
      pipe_in[0].sqb = sqz_w[att_pkg::SQ_W-1:0];
   end

   // Sum of squares, pre-scaled for the square root
   always_comb begin
      pipe_in[1]      = pipe_ff[0];
      pipe_in[1].rem  = RW'({1'b0, pipe_ff[0].sqa} + {1'b0, pipe_ff[0].sqb})
                        << (2 * att_pkg::PRESCALE);
      pipe_in[1].root = '0;
   end

   for (genvar g = 2; g < NST; g++) begin : g_stage
      if (g < 2 + SQS) begin : g_sqrt
         // One result bit of the integer square root per stage
         localparam int K = SQS - 1 - (g - 2);
         logic [RW-1:0] bitv;
         logic [RW:0]   trial;
         assign bitv  = RW'(1) << (2 * K);
         assign trial = {1'b0, pipe_ff[g-1].root} + {1'b0, bitv};
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            if ({1'b0, pipe_ff[g-1].rem} >= trial) begin
               pipe_in[g].rem  = pipe_ff[g-1].rem - trial[RW-1:0];
               pipe_in[g].root = (pipe_ff[g-1].root >> 1) + bitv;
            end else begin
               pipe_in[g].root = pipe_ff[g-1].root >> 1;
            end
         end
      end else begin : g_cordic
         // One vectoring iteration for roll and for pitch
         localparam int J = g - 2 - SQS;
         logic signed [DW-1:0] pxi;
         logic signed [ZW-1:0] ang;
         assign ang = ZW'(att_pkg::ATAN_TAB[J]);
         if (J == 0) begin : g_first
            assign pxi = {1'b0, pipe_ff[g-1].root[DW-2:0]};
         end else begin : g_rest
            assign pxi = pipe_ff[g-1].px;
         end
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            if (!pipe_ff[g-1].ry[DW-1]) begin
               pipe_in[g].rx = pipe_ff[g-1].rx + (pipe_ff[g-1].ry >>> J);
               pipe_in[g].ry = pipe_ff[g-1].ry - (pipe_ff[g-1].rx >>> J);
               pipe_in[g].rz = pipe_ff[g-1].rz + ang;
            end else begin
               pipe_in[g].rx = pipe_ff[g-1].rx - (pipe_ff[g-1].ry >>> J);
               pipe_in[g].ry = pipe_ff[g-1].ry + (pipe_ff[g-1].rx >>> J);
               pipe_in[g].rz = pipe_ff[g-1].rz - ang;
            end
            if (!pipe_ff[g-1].py[DW-1]) begin
               pipe_in[g].px = pxi + (pipe_ff[g-1].py >>> J);
               pipe_in[g].py = pipe_ff[g-1].py - (pxi >>> J);
               pipe_in[g].pz = pipe_ff[g-1].pz + ang;
            end else begin
               pipe_in[g].px = pxi - (pipe_ff[g-1].py >>> J);
               pipe_in[g].py = pipe_ff[g-1].py + (pxi >>> J);
               pipe_in[g].pz = pipe_ff[g-1].pz - ang;
            end
         end
      end
   end

   // Output: round, clamp, add offset, swap
   logic signed [ZW-1:0] rz_rnd, pz_rnd;
   logic signed [AW-1:0] roll_r, pitch_r, roll_c, pitch_c;
   logic signed [AW:0]   roll_sum;
   logic signed [AW-1:0] roll_f;

   assign rz_rnd  = pipe_ff[NST-1].rz + (ZW'(1) <<< (SH - 1));
   assign pz_rnd  = pipe_ff[NST-1].pz + (ZW'(1) <<< (SH - 1));
   assign roll_r  = rz_rnd[ZW-1:SH];
   assign pitch_r = pz_rnd[ZW-1:SH];

   always_comb begin
      if (pipe_ff[NST-1].roll_zero)           roll_c = '0;
      else if (roll_r > att_pkg::ROLL_LIM)    roll_c = AW'(att_pkg::ROLL_LIM);
      else if (roll_r < -att_pkg::ROLL_LIM)   roll_c = AW'(-att_pkg::ROLL_LIM);
      else                                    roll_c = roll_r;

      if (pipe_ff[NST-1].pitch_zero)          pitch_c = '0;
      else if (pitch_r > att_pkg::PITCH_LIM)  pitch_c = AW'(att_pkg::PITCH_LIM);
      else if (pitch_r < -att_pkg::PITCH_LIM) pitch_c = AW'(-att_pkg::PITCH_LIM);
      else                                    pitch_c = pitch_r;

      roll_sum = {roll_c[AW-1], roll_c} + (AW + 1)'(zero_offset_ff);
      if (roll_sum > att_pkg::SUM_LIM)        roll_f = AW'(att_pkg::SUM_LIM);
      else if (roll_sum < -att_pkg::SUM_LIM)  roll_f = AW'(-att_pkg::SUM_LIM);
      else                                    roll_f = roll_sum[AW-1:0];

      if (axis_swap_ff) begin
         roll_out_in  = pitch_c;
         pitch_out_in = roll_f;
      end else begin
         roll_out_in  = roll_f;
         pitch_out_in = pitch_c;
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff      <= pipe_in;
         roll_out_ff  <= roll_out_in;
         pitch_out_ff <= pitch_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[NST-2:0], req_chan.valid};
         out_vld_ff <= vld_ff[NST-1];
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.roll_angle  = roll_out_ff;
   assign rsp_chan.pitch_angle = pitch_out_ff;

endmodule
